@@ design/assert_macros.svh @@
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clk_i edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition that holds on every rising clk_i edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  `ASSERT_IMPL(label, 1'b1, cond, msg)

`endif

@@ design/smts_pkg.sv @@
package smts_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int MAX_ENTRIES = 256;
  localparam int VEC_DEPTH   = 64;

  localparam int EIW = $clog2(MAX_ENTRIES);
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int ACCW = 56;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;
  localparam logic [1:0] ACT_MULT  = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;

  typedef struct packed {
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } ent_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRD   = 9'b000000010,
    S_SCMP  = 9'b000000100,
    S_FIN   = 9'b000001000,
    S_MRD   = 9'b000010000,
    S_MVX   = 9'b000100000,
    S_MMUL  = 9'b001000000,
    S_MACC  = 9'b010000000,
    S_MEMIT = 9'b100000000
  } state_e;

endpackage

@@ design/sparse_matrix_table_spmv_top.sv @@
// channel | direction | handshake              | payload
// input   | in        | in_valid_i / in_stall_o  | action_i row_i col_i value_i
// output  | out       | out_valid_o / out_stall_i| out_row_o out_value_o status_o last_o
//         |           |                          | row_count_o col_count_o entry_count_o
// write and read scan the entry table one stored entry at a time, up to a match
// load skips the table scan
// multiply: for each row, scans every stored entry and multiplies each entry of that row,
// one at a time through the single table read port and the shared multiplier
// reset is asynchronous active low and empties the table and the vector at once
// a result beat waits in the output register while out_stall_i is high
module sparse_matrix_table_spmv_top import smts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [5:0]         row_i,
  input  logic [5:0]         col_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         out_row_o,
  output logic signed [31:0] out_value_o,
  output logic [1:0]         status_o,
  output logic               last_o,
  output logic [6:0]         row_count_o,
  output logic [6:0]         col_count_o,
  output logic [8:0]         entry_count_o
);

  state_e state_q, state_d;

  logic [1:0]         act_q;
  logic [5:0]         row_q;
  logic [5:0]         col_q;
  logic signed [31:0] val_q;

  logic [ECW-1:0] idx_q, idx_d;
  logic           found_q, found_d;
  logic [6:0]     rows_q, rows_d;
  logic [6:0]     cols_q, cols_d;
  logic [ECW-1:0] ents_q, ents_d;
  logic [5:0]     r_q, r_d;
  logic signed [ACCW-1:0] acc_q, acc_d;
  logic signed [63:0]     prod_q;

  ent_t               tbl_mem [MAX_ENTRIES];
  ent_t               tbl_rd_q;
  logic signed [31:0] vec_mem [VEC_DEPTH];
  logic signed [31:0] vec_rd_q;
  logic [VEC_DEPTH-1:0] vld_q;
  logic               vld_rd_q;

  logic               ov_q;
  logic [5:0]         orow_q;
  logic signed [31:0] oval_q;
  logic [1:0]         ost_q;
  logic               olast_q;
  logic [6:0]         orc_q;
  logic [6:0]         occ_q;
  logic [ECW-1:0]     oec_q;

  logic out_free;
  logic in_acc;
  logic tbl_we;
  logic [EIW-1:0] tbl_waddr;
  logic wr_new;
  logic emit;
  logic signed [47:0] trunc;
  logic signed [31:0] sat;
  logic signed [31:0] xval;

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign wr_new    = !found_q && (ents_q != ECW'(MAX_ENTRIES));
  assign tbl_we    = (state_q == S_FIN) && out_free && (act_q == ACT_WRITE) &&
                     (found_q || wr_new) &&
                     ({1'b0, row_q} < 7'(MAX_ROWS)) && ({1'b0, col_q} < 7'(MAX_COLS));
  assign tbl_waddr = found_q ? idx_q[EIW-1:0] : ents_q[EIW-1:0];

  assign xval  = vld_rd_q ? vec_rd_q : 32'sd0;
  assign trunc = prod_q[63:16] + 48'((prod_q[63] && (prod_q[15:0] != 16'd0)) ? 1 : 0);

  always_comb begin
    if (acc_q > ACCW'(64'sh7FFFFFFF)) begin
      sat = 32'sh7FFFFFFF;
    end else if (acc_q < -ACCW'(64'sh80000000)) begin
      sat = 32'sh80000000;
    end else begin
      sat = acc_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    tbl_rd_q <= tbl_mem[idx_q[EIW-1:0]];
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= '{row: row_q, col: col_q, value: val_q};
    end
  end

  always_ff @(posedge clk_i) begin
    vec_rd_q <= vec_mem[tbl_rd_q.col];
    if (in_acc && (action_i == ACT_LOAD) && ({1'b0, col_i} < 7'(MAX_COLS))) begin
      vec_mem[col_i] <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      vld_rd_q <= vld_q[tbl_rd_q.col];
      if (in_acc && (action_i == ACT_LOAD) && ({1'b0, col_i} < 7'(MAX_COLS))) begin
        vld_q[col_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_i;
      row_q <= row_i;
      col_q <= col_i;
      val_q <= value_i;
    end
    if (state_q == S_MMUL) begin
      prod_q <= tbl_rd_q.value * xval;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    found_d = found_q;
    rows_d  = rows_q;
    cols_d  = cols_q;
    ents_d  = ents_q;
    r_d     = r_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d   = '0;
          found_d = 1'b0;
          r_d     = '0;
          acc_d   = '0;
          case (action_i)
            ACT_WRITE, ACT_READ: state_d = (ents_q == '0) ? S_FIN : S_SRD;
            ACT_LOAD:            state_d = S_FIN;
            default:             state_d = (rows_q == '0) ? S_IDLE : S_MRD;
          endcase
        end
      end
      S_SRD: state_d = S_SCMP;
      S_SCMP: begin
        if (tbl_rd_q.row == row_q && tbl_rd_q.col == col_q) begin
          found_d = 1'b1;
          state_d = S_FIN;
        end else if (idx_q + 1'b1 == ents_q) begin
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (tbl_we && !found_q) begin
            ents_d = ents_q + 1'b1;
            if (rows_q < {1'b0, row_q} + 7'd1) rows_d = {1'b0, row_q} + 7'd1;
            if (cols_q < {1'b0, col_q} + 7'd1) cols_d = {1'b0, col_q} + 7'd1;
          end
        end
      end
      S_MRD: state_d = (idx_q == ents_q) ? S_MEMIT : S_MVX;
      S_MVX: begin
        if (tbl_rd_q.row == r_q) begin
          state_d = S_MMUL;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_MRD;
        end
      end
      S_MMUL: state_d = S_MACC;
      S_MACC: begin
        acc_d   = acc_q + ACCW'(trunc);
        idx_d   = idx_q + 1'b1;
        state_d = S_MRD;
      end
      S_MEMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if ({1'b0, r_q} + 7'd1 == rows_q) begin
            state_d = S_IDLE;
          end else begin
            r_d     = r_q + 1'b1;
            idx_d   = '0;
            acc_d   = '0;
            state_d = S_MRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      found_q <= 1'b0;
      rows_q  <= '0;
      cols_q  <= '0;
      ents_q  <= '0;
      r_q     <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
      ents_q  <= ents_d;
      r_q     <= r_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  // result beat, counts taken after the action
  always_ff @(posedge clk_i) begin
    if (emit) begin
      orc_q <= rows_d;
      occ_q <= cols_d;
      oec_q <= ents_d;
      if (state_q == S_MEMIT) begin
        orow_q  <= r_q;
        oval_q  <= sat;
        ost_q   <= STAT_OK;
        olast_q <= ({1'b0, r_q} + 7'd1 == rows_q);
      end else begin
        orow_q  <= '0;
        olast_q <= 1'b1;
        case (act_q)
          ACT_WRITE: begin
            oval_q <= val_q;
            ost_q  <= tbl_we ? STAT_OK : STAT_FULL;
          end
          ACT_READ: begin
            oval_q <= found_q ? tbl_rd_q.value : 32'sd0;
            ost_q  <= found_q ? STAT_OK : STAT_MISSING;
          end
          default: begin
            oval_q <= val_q;
            ost_q  <= STAT_OK;
          end
        endcase
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign out_row_o     = orow_q;
  assign out_value_o   = oval_q;
  assign status_o      = ost_q;
  assign last_o        = olast_q;
  assign row_count_o   = orc_q;
  assign col_count_o   = occ_q;
  assign entry_count_o = oec_q;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_ents_bound, ents_q <= ECW'(MAX_ENTRIES), "entry count overflow")
  `ASSERT_IMPL(a_empty_dims, ents_q == '0, rows_q == '0 && cols_q == '0, "dims without entries")
  `ASSERT_IMPL(a_load_fin, in_acc && action_i == ACT_LOAD, ##1 state_q == S_FIN, "load path")
  `ASSERT_IMPL(a_mult_last, ov_q && olast_q && orow_q != '0, {1'b0, orow_q} + 7'd1 == orc_q,
               "last row mismatch")
  `ASSERT_IMPL(a_scan_bound, state_q == S_MVX || state_q == S_SCMP, idx_q < ents_q,
               "scan past fill")

endmodule

@@ tb/sv/tb_sparse_matrix_table_spmv_top.sv @@
module tb_sparse_matrix_table_spmv_top;
  import smts_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         action_i = ACT_WRITE;
  logic [5:0]         row_i = '0;
  logic [5:0]         col_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [5:0]         out_row_o;
  logic signed [31:0] out_value_o;
  logic [1:0]         status_o;
  logic               last_o;
  logic [6:0]         row_count_o;
  logic [6:0]         col_count_o;
  logic [8:0]         entry_count_o;

  typedef struct {
    logic [5:0]         rrow;
    logic signed [31:0] rval;
    logic [1:0]         rstat;
    logic               rlast;
    logic [6:0]         rcnt;
    logic [6:0]         ccnt;
    logic [8:0]         ecnt;
  } spmv_beat_t;

  spmv_beat_t beat_q[$];

  logic [5:0]         tab_row[MAX_ENTRIES];
  logic [5:0]         tab_col[MAX_ENTRIES];
  logic signed [31:0] tab_val[MAX_ENTRIES];
  logic signed [31:0] x_vec[VEC_DEPTH];
  int unsigned        n_rows, n_cols, n_ents;
  int unsigned        n_fail, n_items, n_beats, n_mults;
  int unsigned        cyc;
  bit                 mon_stall_en;

  sparse_matrix_table_spmv_top u_dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic spmv_beat_t mk_beat(logic [5:0] r, logic signed [31:0] v,
                                         logic [1:0] st, logic l);
    spmv_beat_t b;
    b.rrow = r; b.rval = v; b.rstat = st; b.rlast = l;
    b.rcnt = n_rows[6:0]; b.ccnt = n_cols[6:0]; b.ecnt = n_ents[8:0];
    return b;
  endfunction

  function automatic int find_ent(logic [5:0] r, logic [5:0] c);
    for (int k = 0; k < n_ents; k++)
      if (tab_row[k] == r && tab_col[k] == c) return k;
    return -1;
  endfunction

  function automatic longint q16_mul(longint a, longint b);
    longint ma, mb, p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb) >>> 16;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  task automatic predict_spmv(logic [1:0] act, logic [5:0] r, logic [5:0] c,
                              logic signed [31:0] v);
    int k;
    longint acc;
    case (act)
      ACT_WRITE: begin
        k = find_ent(r, c);
        if (k >= 0) begin
          tab_val[k] = v;
          beat_q.push_back(mk_beat(0, v, STAT_OK, 1));
        end else if (n_ents >= MAX_ENTRIES) begin
          beat_q.push_back(mk_beat(0, v, STAT_FULL, 1));
        end else begin
          tab_row[n_ents] = r; tab_col[n_ents] = c; tab_val[n_ents] = v;
          n_ents++;
          if (n_rows < r + 1) n_rows = r + 1;
          if (n_cols < c + 1) n_cols = c + 1;
          beat_q.push_back(mk_beat(0, v, STAT_OK, 1));
        end
      end
      ACT_READ: begin
        k = find_ent(r, c);
        if (k < 0) beat_q.push_back(mk_beat(0, 0, STAT_MISSING, 1));
        else beat_q.push_back(mk_beat(0, tab_val[k], STAT_OK, 1));
      end
      ACT_LOAD: begin
        x_vec[c] = v;
        beat_q.push_back(mk_beat(0, v, STAT_OK, 1));
      end
      default: begin
        n_mults++;
        for (int rr = 0; rr < n_rows; rr++) begin
          acc = 0;
          for (int e = 0; e < n_ents; e++)
            if (tab_row[e] == rr) acc += q16_mul(longint'(tab_val[e]),
                                                 longint'(x_vec[tab_col[e]]));
          if (acc > 64'sh7FFFFFFF) acc = 64'sh7FFFFFFF;
          if (acc < -64'sh80000000) acc = -64'sh80000000;
          beat_q.push_back(mk_beat(rr[5:0], acc[31:0], STAT_OK, rr + 1 == n_rows));
        end
      end
    endcase
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [1:0] act, logic [5:0] r, logic [5:0] c,
                           logic signed [31:0] v);
    repeat (1 + rand_gap()) @(negedge clk_i);
    action_i <= act; row_i <= r; col_i <= c; value_i <= v;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_spmv(act, r, c, v);
    n_items++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (beat_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // random out_stall with long bursts now and then
  initial begin
    forever begin
      @(negedge clk_i);
      if (mon_stall_en && $urandom_range(0, 99) < 25) begin
        out_stall_i <= 1'b1;
        repeat (rand_gap()) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    spmv_beat_t b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_beats++;
      if (beat_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        b = beat_q.pop_front();
        if (out_row_o !== b.rrow) begin
          $error("out_row exp %0d got %0d", b.rrow, out_row_o); n_fail++;
        end
        if (out_value_o !== b.rval) begin
          $error("out_value exp %0d got %0d", b.rval, out_value_o); n_fail++;
        end
        if (status_o !== b.rstat) begin
          $error("status exp %0d got %0d", b.rstat, status_o); n_fail++;
        end
        if (last_o !== b.rlast) begin
          $error("last exp %0d got %0d", b.rlast, last_o); n_fail++;
        end
        if (row_count_o !== b.rcnt) begin
          $error("row_count exp %0d got %0d", b.rcnt, row_count_o); n_fail++;
        end
        if (col_count_o !== b.ccnt) begin
          $error("col_count exp %0d got %0d", b.ccnt, col_count_o); n_fail++;
        end
        if (entry_count_o !== b.ecnt) begin
          $error("entry_count exp %0d got %0d", b.ecnt, entry_count_o); n_fail++;
        end
      end
    end
  end

  task automatic test_empty();
    send_item(ACT_MULT, 0, 0, 0);
    send_item(ACT_READ, 63, 63, 0);
    send_item(ACT_READ, 0, 0, 0);
  endtask

  task automatic test_directed();
    send_item(ACT_WRITE, 0, 0, 32'sh0001_0000);
    send_item(ACT_WRITE, 63, 63, 32'sh7FFF_FFFF);
    send_item(ACT_WRITE, 63, 0, 32'sh8000_0000);
    send_item(ACT_WRITE, 5, 7, 0);
    send_item(ACT_WRITE, 0, 0, 32'shFFFF_8000);
    send_item(ACT_READ, 0, 0, 0);
    send_item(ACT_READ, 5, 7, 0);
    send_item(ACT_READ, 7, 5, 0);
    send_item(ACT_MULT, 0, 0, 0);
    send_item(ACT_LOAD, 0, 0, 32'sh0002_0000);
    send_item(ACT_LOAD, 0, 63, 32'sh7FFF_FFFF);
    send_item(ACT_LOAD, 0, 7, 32'shFFFF_FFFF);
    send_item(ACT_WRITE, 63, 63, 32'sh7FFF_FFFF);
    send_item(ACT_MULT, 0, 0, 0);
    send_item(ACT_LOAD, 63, 0, 32'sh8000_0000);
    send_item(ACT_MULT, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    logic [1:0] act;
    logic [5:0] r, c;
    logic signed [31:0] v;
    for (int i = 0; i < count; i++) begin
      act = $urandom_range(0, 9) < 4 ? ACT_WRITE :
            ($urandom_range(0, 2) == 0 ? ACT_READ :
            ($urandom_range(0, 3) == 0 ? ACT_MULT : ACT_LOAD));
      r = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 7));
      c = 6'($urandom);
      v = $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      send_item(act, r, c, v);
      if (i == count / 2) drain_results();
    end
    send_item(ACT_MULT, 0, 0, 0);
  endtask

  initial begin
    n_rows = 0; n_cols = 0; n_ents = 0; n_fail = 0; cyc = 0;
    n_items = 0; n_beats = 0; n_mults = 0; mon_stall_en = 0;
    for (int i = 0; i < VEC_DEPTH; i++) x_vec[i] = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_empty();
    mon_stall_en = 1;
    test_directed();
    drain_results();
    test_random(60);
    mon_stall_en = 0;
    test_random(20);
    mon_stall_en = 1;
    drain_results();
    repeat (50) @(negedge clk_i);
    $display("run: %0d items, %0d result beats, %0d multiplies", n_items, n_beats, n_mults);
    $display("covered write/read/load/multiply, overwrite, missing entry, empty matrix");
    if (n_fail == 0 && beat_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
